### sv/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared types and constants for the sorted priority queue with bump.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;

  // Command codes.
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  // Status codes.
  localparam logic [2:0] STS_OK     = 3'd0;
  localparam logic [2:0] STS_BUMPED = 3'd1;
  localparam logic [2:0] STS_FULL   = 3'd2;
  localparam logic [2:0] STS_EMPTY  = 3'd3;
  localparam logic [2:0] STS_RANGE  = 3'd4;

  // Operations broadcast to every cell of the row.
  localparam logic [1:0] OP_HOLD       = 2'd0;
  localparam logic [1:0] OP_PLACE      = 2'd1;
  localparam logic [1:0] OP_TAKE_MATCH = 2'd2;
  localparam logic [1:0] OP_TAKE_HEAD  = 2'd3;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] item;
    logic signed [31:0] priority_req;
    logic [3:0]         index;
  } spq_in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] head_priority;
    logic [4:0]         count;
    logic [2:0]         status;
  } spq_out_t;

  typedef struct packed {
    logic signed [31:0] item;
    logic signed [31:0] pri;
  } spq_ent_t;

endpackage

### sv/spq_cell.sv
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry and moves it, keeps it or takes the new pair each cycle.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic              clk,
  input  logic [1:0]        op,
  input  spq_pkg::spq_ent_t key,
  input  logic              occ,
  input  logic              first,
  input  logic              left_ge,
  input  logic              cut_in,
  input  spq_pkg::spq_ent_t left_ent,
  input  spq_pkg::spq_ent_t right_ent,
  output spq_pkg::spq_ent_t ent,
  output logic              ge,
  output logic              match,
  output logic              cut_out
);
  import spq_pkg::*;

  spq_ent_t ent_r;
  spq_ent_t ent_nxt;
  logic     hit;

  // A stored entry stays ahead of a new pair of equal priority.
  assign ge    = occ && (ent_r.pri >= key.pri);
  assign match = occ && (ent_r.item == key.item);

  assign hit     = ((op == OP_TAKE_MATCH) && match) ||
                   ((op == OP_TAKE_HEAD) && first);
  assign cut_out = cut_in || hit;

  always_comb begin
    ent_nxt = ent_r;
    case (op)
      OP_PLACE: begin
        if (!ge) begin
          if (left_ge) begin
            ent_nxt.item = key.item;
            ent_nxt.pri  = key.pri;
          end else begin
            ent_nxt = left_ent;
          end
        end
      end
      OP_TAKE_MATCH, OP_TAKE_HEAD: begin
        if (cut_out) begin
          ent_nxt = right_ent;
        end
      end
      default: begin
        ent_nxt = ent_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;

endmodule

### sv/sorted_priority_queue_with_bump.sv
// ----------------------------------------------------------------------------
// Sorted priority queue with bump
// Bounded store of (item, priority) pairs kept sorted, highest priority first.
// ----------------------------------------------------------------------------
// Usage: a command is transferred at a rising edge where start is high and
// busy is low; in_data carries the command, item, requested priority and
// read index. Insert places a new pair behind all entries of equal or higher
// priority. Inserting an item that is already stored ignores the requested
// priority and moves that entry up with its own priority plus one
// (saturating). Remove takes the head entry, and read returns the item at a
// position counted from the head.
// Each command produces exactly one result, shown on out_data for a single
// cycle with out_valid high: the cycle after the command edge, or for a bump
// the cycle after its bump state. Inserts, removes and reads finish at the
// command edge; a bump first closes the gap left by the old entry and then,
// in the bump state, opens a gap at the new position. busy is high during
// the bump state only, so the sustained rate is one command per cycle while
// no bump holds busy high.
// The result also reports the count and head priority after the command.
// Reset clears the count, the result strobe and the control state; entry
// contents are not cleared and only occupied cells are ever looked at.
// The receiver cannot stall: a result is taken in the cycle it is shown.
// ----------------------------------------------------------------------------
module sorted_priority_queue_with_bump (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  spq_pkg::spq_in_t in_data,
  output logic             out_valid,
  output spq_pkg::spq_out_t out_data
);
  import spq_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUMP = 1'b1;

  logic               state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] value_r, value_nxt;
  logic [2:0]         status_r, status_nxt;
  logic signed [31:0] bump_item_r, bump_item_nxt;
  logic signed [31:0] bump_pri_r, bump_pri_nxt;

  logic [1:0]         row_op;
  spq_ent_t           row_key;
  spq_ent_t           ent   [DEPTH];
  logic [DEPTH-1:0]   ge_v;
  logic [DEPTH-1:0]   match_v;
  logic [DEPTH-1:0]   cut_v;
  logic               found;
  logic signed [31:0] old_pri;
  logic               accept;

  // The key broadcast to the row: the incoming pair, or the pair being put
  // back during the bump state. It depends only on registers and inputs, so
  // the match search can steer the row operation.
  assign row_key = (state_r == ST_BUMP) ? {bump_item_r, bump_pri_r}
                                        : {in_data.item, in_data.priority_req};

  // The row of cells. Each cell sees its neighbors' entries and flags; the
  // gap-closing chain (cut) runs from head to tail.
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic     occ;
    logic     left_ge;
    logic     cut_in;
    spq_ent_t left_ent;
    spq_ent_t right_ent;

    assign occ = (CNT_W'(k) < count_r);

    if (k == 0) begin : g_head
      assign left_ge  = 1'b1;
      assign cut_in   = 1'b0;
      assign left_ent = ent[k];
    end else begin : g_body
      assign left_ge  = ge_v[k-1];
      assign cut_in   = cut_v[k-1];
      assign left_ent = ent[k-1];
    end

    if (k == DEPTH - 1) begin : g_tail
      assign right_ent = ent[k];
    end else begin : g_inner
      assign right_ent = ent[k+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .op        (row_op),
      .key       (row_key),
      .occ       (occ),
      .first     (k == 0),
      .left_ge   (left_ge),
      .cut_in    (cut_in),
      .left_ent  (left_ent),
      .right_ent (right_ent),
      .ent       (ent[k]),
      .ge        (ge_v[k]),
      .match     (match_v[k]),
      .cut_out   (cut_v[k])
    );
  end

  // Stored items are unique, so at most one cell matches and an AND-OR
  // picks its priority.
  assign found = |match_v;

  always_comb begin
    old_pri = '0;
    for (int k = 0; k < DEPTH; k++) begin
      old_pri = old_pri | (ent[k].pri & {32{match_v[k]}});
    end
  end

  assign busy   = (state_r == ST_BUMP);
  assign accept = start && !busy;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    value_nxt     = value_r;
    status_nxt    = status_r;
    bump_item_nxt = bump_item_r;
    bump_pri_nxt  = bump_pri_r;
    row_op        = OP_HOLD;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          value_nxt     = '0;
          status_nxt    = STS_OK;
          case (in_data.cmd)
            CMD_INSERT: begin
              if (found) begin
                // Close the gap now, reinsert in the next cycle.
                row_op        = OP_TAKE_MATCH;
                count_nxt     = count_r - CNT_W'(1);
                bump_item_nxt = in_data.item;
                bump_pri_nxt  = (old_pri == INT_MAX) ? INT_MAX : old_pri + 32'sd1;
                out_valid_nxt = 1'b0;
                state_nxt     = ST_BUMP;
              end else if (count_r == CNT_W'(DEPTH)) begin
                status_nxt = STS_FULL;
              end else begin
                row_op    = OP_PLACE;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            CMD_REMOVE: begin
              if (count_r == '0) begin
                status_nxt = STS_EMPTY;
              end else begin
                row_op    = OP_TAKE_HEAD;
                value_nxt = ent[0].item;
                count_nxt = count_r - CNT_W'(1);
              end
            end
            CMD_READ: begin
              if (CNT_W'(in_data.index) < count_r) begin
                value_nxt = ent[in_data.index].item;
              end else begin
                value_nxt  = INT_MIN;
                status_nxt = STS_RANGE;
              end
            end
            default: begin
              status_nxt = STS_OK;
            end
          endcase
        end
      end
      ST_BUMP: begin
        row_op        = OP_PLACE;
        count_nxt     = count_r + CNT_W'(1);
        value_nxt     = '0;
        status_nxt    = STS_BUMPED;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r     <= value_nxt;
    status_r    <= status_nxt;
    bump_item_r <= bump_item_nxt;
    bump_pri_r  <= bump_pri_nxt;
  end

  // Count and head priority come straight from the count register and the row,
  // which already hold the state after the command while the result is shown.
  assign out_valid              = out_valid_r;
  assign out_data.value         = value_r;
  assign out_data.head_priority = (count_r == '0) ? INT_MIN : ent[0].pri;
  assign out_data.count         = count_r;
  assign out_data.status        = status_r;

endmodule

### verif/tb_sorted_priority_queue_with_bump.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the sorted priority queue with bump
// Drives insert, remove, read and unused commands through the start/busy
// handshake and predicts every result with a behavioral copy of the sorted
// store. Each strobed result is checked field by field against the oldest
// prediction while the sender's idle rate changes from phase to phase.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue_with_bump;
  import spq_pkg::*;

  // Command code 3 is unused by the block and must behave as a no-op.
  localparam logic [1:0] CMD_NOP = 2'd3;

  // The limit leaves a wide margin over the slowest correct run.
  localparam int CYCLE_LIMIT = 100000;

  // After the last result, the bench keeps sampling so that a stray result
  // would still be caught.
  localparam int DRAIN_CYCLES = 8;

  // One queued command together with the sender's idle rate, in percent,
  // that applies while it waits to be presented.
  typedef struct {
    spq_in_t cmd;
    int      idle_pct;
  } backlog_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  spq_in_t  in_data = '0;
  logic     out_valid;
  spq_out_t out_data;

  backlog_t cmd_backlog[$];
  spq_out_t pending_results[$];
  int       mismatch_count = 0;
  int       cycle_count = 0;

  // Shadow of the sorted store: entries below store_fill are ordered by
  // priority, highest first, and equal priorities keep their arrival order.
  logic signed [31:0] store_item [DEPTH];
  logic signed [31:0] store_prio [DEPTH];
  int                 store_fill = 0;

  // Item codes that the random part draws from. A small pool makes repeated
  // inserts of stored items, and therefore bumps, common.
  logic signed [31:0] item_pool [24];

  sorted_priority_queue_with_bump dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Places a pair behind every entry of equal or higher priority.
  function automatic void place_sorted(logic signed [31:0] it, logic signed [31:0] pr);
    int pos;
    pos = 0;
    while (pos < store_fill && store_prio[pos] >= pr) pos++;
    for (int k = store_fill; k > pos; k--) begin
      store_item[k] = store_item[k-1];
      store_prio[k] = store_prio[k-1];
    end
    store_item[pos] = it;
    store_prio[pos] = pr;
    store_fill++;
  endfunction

  // Removes the entry at a position and closes the gap behind it.
  function automatic void take_at(int pos);
    for (int k = pos; k + 1 < store_fill; k++) begin
      store_item[k] = store_item[k+1];
      store_prio[k] = store_prio[k+1];
    end
    store_fill--;
  endfunction

  // Applies one accepted command to the shadow store and returns the result
  // that the block has to show for it.
  function automatic spq_out_t predict_queue_result(spq_in_t req);
    spq_out_t           res;
    int                 hit;
    logic signed [31:0] raised;
    res.value  = '0;
    res.status = STS_OK;
    case (req.cmd)
      CMD_INSERT: begin
        // The whole store is searched for the item, not just the part
        // ahead of where the new pair would land.
        hit = -1;
        for (int k = 0; k < store_fill; k++) begin
          if (hit < 0 && store_item[k] == req.item) hit = k;
        end
        if (hit >= 0) begin
          // A bump keeps the stored priority, raised by one and saturated.
          raised = (store_prio[hit] == INT_MAX) ? INT_MAX : store_prio[hit] + 1;
          take_at(hit);
          place_sorted(req.item, raised);
          res.status = STS_BUMPED;
        end else if (store_fill >= DEPTH) begin
          res.status = STS_FULL;
        end else begin
          place_sorted(req.item, req.priority_req);
        end
      end
      CMD_REMOVE: begin
        if (store_fill == 0) begin
          res.status = STS_EMPTY;
        end else begin
          res.value = store_item[0];
          take_at(0);
        end
      end
      CMD_READ: begin
        if (req.index < store_fill) begin
          res.value = store_item[req.index];
        end else begin
          res.value  = INT_MIN;
          res.status = STS_RANGE;
        end
      end
      default: begin
        // The unused code leaves the store alone and reports plain success.
      end
    endcase
    res.head_priority = (store_fill == 0) ? INT_MIN : store_prio[0];
    res.count         = store_fill[4:0];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic void queue_cmd(logic [1:0] op, logic signed [31:0] it,
                                    logic signed [31:0] pr, logic [3:0] at,
                                    int idle_pct);
    backlog_t b;
    b.cmd.cmd          = op;
    b.cmd.item         = it;
    b.cmd.priority_req = pr;
    b.cmd.index        = at;
    b.idle_pct         = idle_pct;
    cmd_backlog.push_back(b);
  endfunction

  // Mostly pool members, sometimes a fresh code that is unlikely to be stored.
  function automatic logic signed [31:0] pick_item();
    if ($urandom_range(99) < 85) return item_pool[$urandom_range(23)];
    return $urandom;
  endfunction

  // Small values give many ties, values near the ends exercise signed
  // ordering and saturation, and the rest cover every bit.
  function automatic logic signed [31:0] pick_priority();
    int roll;
    roll = $urandom_range(99);
    if (roll < 35) return $signed($urandom_range(4)) - 2;
    if (roll < 50) return INT_MAX - $urandom_range(2);
    if (roll < 58) return INT_MIN + $urandom_range(2);
    return $urandom;
  endfunction

  // The insert share steers the fill level: a high share pushes the store
  // toward full, where refusals and bumps of a full store happen, and a low
  // share drains it toward empty removes.
  function automatic void queue_random_cmd(int insert_pct, int idle_pct);
    int         roll;
    logic [1:0] op;
    roll = $urandom_range(99);
    if (roll < insert_pct) op = CMD_INSERT;
    else if (roll < 88) op = CMD_REMOVE;
    else if (roll < 98) op = CMD_READ;
    else op = CMD_NOP;
    // Fields that the command does not use still carry random values.
    queue_cmd(op, pick_item(), pick_priority(), 4'($urandom_range(15)), idle_pct);
  endfunction

  // --------------------------------------------------------------------------
  // Driver
  // --------------------------------------------------------------------------

  // A command is transferred at an edge where start is high and busy is low.
  // The prediction is made at that edge, ahead of its result. While busy
  // holds a command off, start and in_data stay as they are; otherwise the
  // next command is presented or the sender idles with random data on
  // in_data, which the block has to ignore.
  always @(posedge clk) begin : drive_proc
    backlog_t nxt;
    spq_in_t  noise;
    if (rst_n) begin
      if (start && busy === 1'b0) begin
        pending_results.push_back(predict_queue_result(in_data));
      end
      if (!start || busy === 1'b0) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= cmd_backlog[0].idle_pct) begin
          nxt = cmd_backlog.pop_front();
          start   <= 1'b1;
          in_data <= nxt.cmd;
        end else begin
          noise.cmd          = 2'($urandom);
          noise.item         = $urandom;
          noise.priority_req = $urandom;
          noise.index        = 4'($urandom);
          start   <= 1'b0;
          in_data <= noise;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor
  // --------------------------------------------------------------------------

  // A result is valid for exactly one cycle and is taken at the edge that
  // ends it. An unknown strobe counts as a result so that it cannot slip by.
  always @(posedge clk) begin : check_proc
    spq_out_t want;
    if (rst_n && out_valid !== 1'b0) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no command outstanding: value %0d status %0d",
               out_data.value, out_data.status);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.value !== want.value) begin
          $error("value: expected %0d, got %0d", want.value, out_data.value);
          mismatch_count++;
        end
        if (out_data.head_priority !== want.head_priority) begin
          $error("head_priority: expected %0d, got %0d",
                 want.head_priority, out_data.head_priority);
          mismatch_count++;
        end
        if (out_data.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, out_data.count);
          mismatch_count++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          mismatch_count++;
        end
      end
    end
  end

  // A hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin : stimulus_proc
    // Sender idle rate per phase, in percent. The receiver cannot hold
    // results off, so the light phase stands in for the mixed one.
    int idle_by_phase [3];
    int bursts;
    idle_by_phase = '{0, 71, 7};

    item_pool[0] = INT_MIN;
    item_pool[1] = INT_MAX;
    item_pool[2] = 0;
    item_pool[3] = -1;
    for (int k = 4; k < 24; k++) item_pool[k] = $urandom;

    // Directed part. Empty store: remove, read and the unused code.
    queue_cmd(CMD_REMOVE, -1, -1, 4'hf, 0);
    queue_cmd(CMD_READ, 0, 0, 4'd0, 0);
    queue_cmd(CMD_NOP, INT_MIN, INT_MAX, 4'hf, 0);
    // Extreme items and priorities, including the signed ends.
    queue_cmd(CMD_INSERT, INT_MIN, INT_MAX, 4'd0, 0);
    queue_cmd(CMD_INSERT, INT_MAX, INT_MIN, 4'hf, 0);
    queue_cmd(CMD_INSERT, 0, 0, 4'd0, 0);
    queue_cmd(CMD_INSERT, -1, -1, 4'd0, 0);
    // Bump at the top priority saturates; the requested priority is ignored.
    queue_cmd(CMD_INSERT, INT_MIN, 5, 4'd0, 0);
    // Bump of the stored item at the lowest priority, with a high request.
    queue_cmd(CMD_INSERT, INT_MAX, INT_MAX, 4'd0, 0);
    // An equal priority lands behind the older entry.
    queue_cmd(CMD_INSERT, 5, 0, 4'd0, 0);
    queue_cmd(CMD_READ, 0, 0, 4'd2, 0);
    // Index equal to the count is out of range.
    queue_cmd(CMD_READ, 0, 0, 4'd5, 0);
    // Fill the store with a spread of tied priorities.
    for (int k = 0; k < 11; k++) queue_cmd(CMD_INSERT, 100 + k, (k % 3) - 1, 4'd0, 0);
    // Full store: a new item is refused, a stored one is still bumped.
    queue_cmd(CMD_INSERT, 777, INT_MAX, 4'd0, 0);
    queue_cmd(CMD_INSERT, -1, INT_MIN, 4'd0, 0);
    queue_cmd(CMD_READ, 0, 0, 4'hf, 0);
    queue_cmd(CMD_REMOVE, 0, 0, 4'd0, 0);

    // Random part: bursts that alternately fill and drain the store, with a
    // pool member replaced by a fresh code at the start of each burst.
    for (int ph = 0; ph < 3; ph++) begin
      for (int b = 0; b < 14; b++) begin
        item_pool[$urandom_range(23, 4)] = $urandom;
        bursts = $urandom_range(56, 20);
        repeat (bursts) queue_random_cmd((b % 2 == 0) ? 62 : 34, idle_by_phase[ph]);
      end
    end

    // Reset is held low at the start and released at a rising edge.
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Sampling at the falling edge keeps this check clear of the edge that
    // moves the driver and the block.
    while (cmd_backlog.size() != 0 || start || pending_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
